### hdl/sorted_key_table_defines.svh
// Assertion macros for the sorted key table.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SKT_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### hdl/skt_pkg.sv
// Shared sizes and codes for the sorted key table.
package skt_pkg;

	localparam int DEPTH        = 16;
	localparam int HANDLE_WIDTH = 16;
	localparam int KEY_W        = 32;
	localparam int PAYLOAD_W    = 16;
	localparam int FUNC_W       = 3;
	localparam int INDEX_W      = 4;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 5;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int ENTRY_W      = KEY_W + HANDLE_WIDTH;

	localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REM_KEY  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_CONTAINS = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ_IDX = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REM_IDX  = 3'd4;

	localparam logic [STATUS_W-1:0] RS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] RS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] RS_BAD_INDEX = 2'd2;
	localparam logic [STATUS_W-1:0] RS_FULL      = 2'd3;

endpackage

### hdl/sorted_key_table.sv
// Sorted key table: top level with the RAM walk sequencer.
// A bad index, full table, empty-table search or unused code goes straight to the result;
// insert shifts entries up from the top; key search scans upward, read by index reads
// the entry directly, and removal then shifts the entries above it down.
// One word at a time: the request side stalls until the result is loaded into the output
// register, so a new word is taken only after the last one is done.
// Reset clears the entry count and the control state; the RAM contents are not cleared.
`include "sorted_key_table_defines.svh"

module sorted_key_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [skt_pkg::FUNC_W-1:0]        func,
	input  logic signed [skt_pkg::KEY_W-1:0]  key,
	input  logic [skt_pkg::PAYLOAD_W-1:0]     payload,
	input  logic [skt_pkg::INDEX_W-1:0]       index,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [skt_pkg::STATUS_W-1:0]      status,
	output logic signed [skt_pkg::KEY_W-1:0]  found_key,
	output logic [skt_pkg::PAYLOAD_W-1:0]     found_payload,
	output logic [skt_pkg::COUNT_W-1:0]       entry_count
);

	import skt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_INS   = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_RDIX  = 6'b001000,
		ST_SHIFT = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [COUNT_W-1:0]      count_q;
	logic [COUNT_W-1:0]      ptr_q, ptr_d;
	logic [FUNC_W-1:0]       func_q;
	logic signed [KEY_W-1:0] key_q;
	logic [HANDLE_WIDTH-1:0] handle_q;

	logic [STATUS_W-1:0]     res_status_q, res_status_d;
	logic signed [KEY_W-1:0] res_key_q, res_key_d;
	logic [HANDLE_WIDTH-1:0] res_handle_q, res_handle_d;
	logic                    res_ld;

	logic                    rsp_valid_q;
	logic [STATUS_W-1:0]     rsp_status_q;
	logic signed [KEY_W-1:0] rsp_key_q;
	logic [PAYLOAD_W-1:0]    rsp_payload_q;
	logic [COUNT_W-1:0]      rsp_count_q;

	logic                    ram_wr_en, ram_rd_en;
	logic [ADDR_W-1:0]       ram_wr_addr, ram_rd_addr;
	logic [ENTRY_W-1:0]      ram_wr_data, ram_rd_data;

	logic signed [KEY_W-1:0] rd_key;
	logic [HANDLE_WIDTH-1:0] rd_handle;
	logic [ENTRY_W-1:0]      new_entry;
	logic [COUNT_W-1:0]      ptr_m1, ptr_m2, ptr_p1, ptr_p2, count_after;
	logic                    req_take, rsp_load, ins_shift;

	skt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign rd_key    = ram_rd_data[ENTRY_W-1 -: KEY_W];
	assign rd_handle = ram_rd_data[HANDLE_WIDTH-1:0];
	assign new_entry = {key_q, handle_q};

	assign ptr_m1 = ptr_q - COUNT_W'(1);
	assign ptr_m2 = ptr_q - COUNT_W'(2);
	assign ptr_p1 = ptr_q + COUNT_W'(1);
	assign ptr_p2 = ptr_q + COUNT_W'(2);

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && (state_q == ST_IDLE);
	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	// entry below the insert point moves up unless it is smaller, or it is
	// the first entry and equals the new key (new word then lands after it)
	assign ins_shift = !(rd_key < key_q) && !((ptr_q == COUNT_W'(1)) && (rd_key == key_q));

	always_comb begin
		count_after = count_q;
		if (res_status_q == RS_OK) begin
			case (func_q)
				FN_INSERT:              count_after = count_q + COUNT_W'(1);
				FN_REM_KEY, FN_REM_IDX: count_after = count_q - COUNT_W'(1);
				default:                count_after = count_q;
			endcase
		end
	end

	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		res_ld       = 1'b0;
		res_status_d = res_status_q;
		res_key_d    = res_key_q;
		res_handle_d = res_handle_q;
		ram_rd_en    = 1'b0;
		ram_rd_addr  = '0;
		ram_wr_en    = 1'b0;
		ram_wr_addr  = '0;
		ram_wr_data  = ram_rd_data;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					res_ld       = 1'b1;
					res_status_d = RS_OK;
					res_key_d    = '0;
					res_handle_d = '0;
					state_d      = ST_FIN;
					case (func)
						FN_INSERT: begin
							if (count_q == COUNT_W'(DEPTH)) begin
								res_status_d = RS_FULL;
							end else begin
								ptr_d       = count_q;
								ram_rd_en   = (count_q != '0);
								ram_rd_addr = ADDR_W'(count_q - COUNT_W'(1));
								state_d     = ST_INS;
							end
						end
						FN_REM_KEY, FN_CONTAINS: begin
							if (count_q == '0) begin
								res_status_d = RS_NOT_FOUND;
							end else begin
								ptr_d       = '0;
								ram_rd_en   = 1'b1;
								ram_rd_addr = '0;
								state_d     = ST_SCAN;
							end
						end
						FN_READ_IDX, FN_REM_IDX: begin
							if (32'(index) >= 32'(count_q)) begin
								res_status_d = RS_BAD_INDEX;
							end else begin
								ptr_d       = COUNT_W'(index);
								ram_rd_en   = 1'b1;
								ram_rd_addr = ADDR_W'(index);
								state_d     = ST_RDIX;
							end
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_INS: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = ADDR_W'(ptr_q);
				if (ptr_q != '0 && ins_shift) begin
					ram_wr_data = ram_rd_data;
					ptr_d       = ptr_m1;
					ram_rd_en   = (ptr_m1 != '0);
					ram_rd_addr = ADDR_W'(ptr_m2);
				end else begin
					ram_wr_data = new_entry;
					state_d     = ST_FIN;
				end
			end
			ST_SCAN: begin
				if (rd_key == key_q) begin
					if (func_q == FN_REM_KEY) begin
						res_ld       = 1'b1;
						res_key_d    = rd_key;
						res_handle_d = rd_handle;
						if (ptr_p1 < count_q) begin
							ram_rd_en   = 1'b1;
							ram_rd_addr = ADDR_W'(ptr_p1);
							state_d     = ST_SHIFT;
						end else begin
							state_d = ST_FIN;
						end
					end else begin
						state_d = ST_FIN;
					end
				end else if (ptr_p1 == count_q) begin
					res_ld       = 1'b1;
					res_status_d = RS_NOT_FOUND;
					state_d      = ST_FIN;
				end else begin
					ptr_d       = ptr_p1;
					ram_rd_en   = 1'b1;
					ram_rd_addr = ADDR_W'(ptr_p1);
				end
			end
			ST_RDIX: begin
				res_ld       = 1'b1;
				res_key_d    = rd_key;
				res_handle_d = rd_handle;
				if (func_q == FN_REM_IDX && ptr_p1 < count_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = ADDR_W'(ptr_p1);
					state_d     = ST_SHIFT;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SHIFT: begin
				// close the gap: entry at ptr+1 moves down to ptr
				ram_wr_en   = 1'b1;
				ram_wr_addr = ADDR_W'(ptr_q);
				ram_wr_data = ram_rd_data;
				ptr_d       = ptr_p1;
				if (ptr_p2 < count_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = ADDR_W'(ptr_p2);
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				count_q     <= count_after;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (req_take) begin
			func_q   <= func;
			key_q    <= key;
			handle_q <= payload[HANDLE_WIDTH-1:0];
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_key_q    <= res_key_d;
			res_handle_q <= res_handle_d;
		end
		if (rsp_load) begin
			rsp_status_q  <= res_status_q;
			rsp_key_q     <= res_key_q;
			rsp_payload_q <= PAYLOAD_W'(res_handle_q);
			rsp_count_q   <= count_after;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign found_key     = rsp_key_q;
	assign found_payload = rsp_payload_q;
	assign entry_count   = rsp_count_q;

	`SKT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= COUNT_W'(DEPTH), "entry count beyond depth")
	`SKT_ASSERT_NOW(a_full_count, rsp_valid_q && rsp_status_q == RS_FULL,
		rsp_count_q == COUNT_W'(DEPTH), "full status with table not full")
	`SKT_ASSERT_NXT(a_busy_after_take, req_take, state_q != ST_IDLE,
		"sequencer idle right after taking a word")

endmodule

### hdl/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
